@@ hdl/bchd_pkg.sv @@
// Shared types and constants for the button click / hold detector.
// Used by bchd_fsm and button_click_hold_detector; depends on nothing else.
package bchd_pkg;

  localparam int TimerW     = 16;
  localparam int MaxClicks  = 15;
  localparam int CountW     = $clog2(MaxClicks + 1);
  localparam int TotalW     = 4;

  localparam logic [TimerW-1:0] DebounceReset = TimerW'(50);
  localparam logic [TimerW-1:0] WindowReset   = TimerW'(400);
  localparam logic [TimerW-1:0] TimerMax      = '1;

  typedef enum logic [2:0] {
    MODE_IDLE     = 3'd0,
    MODE_ALMOST   = 3'd1,
    MODE_PRESSED  = 3'd2,
    MODE_RELEASED = 3'd3,
    MODE_HELD     = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    EV_NONE          = 2'd0,
    EV_HOLDING       = 2'd1,
    EV_HOLD_RELEASED = 2'd2,
    EV_CLICKS_DONE   = 2'd3
  } event_t;

  typedef enum logic {
    REG_DEBOUNCE = 1'b0,
    REG_WINDOW   = 1'b1
  } reg_index_t;

  typedef struct packed {
    event_t              event_kind;
    logic [TotalW-1:0]   click_total;
    mode_t               button_mode;
  } result_t;

endpackage

@@ hdl/bchd_fsm.sv @@
// Button state machine with its debounce and click-window timers and settings.
// Depends on bchd_pkg for the mode, event and result types.
module bchd_fsm (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic                           cfg_index,
  input  logic [bchd_pkg::TimerW-1:0]    cfg_data,
  input  logic                           step,
  input  logic                           pin_level,
  output bchd_pkg::result_t              result
);
  import bchd_pkg::*;

  logic [TimerW-1:0] debounce_ticks;
  logic [TimerW-1:0] click_window_ticks;

  mode_t             mode, mode_next;
  logic [CountW-1:0] click_count, click_count_next;
  logic [TimerW-1:0] window_elapsed, window_elapsed_next;
  logic              window_running, window_running_next;
  logic [TimerW-1:0] debounce_elapsed, debounce_elapsed_next;
  logic              debounce_running, debounce_running_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks     <= DebounceReset;
      click_window_ticks <= WindowReset;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_DEBOUNCE: debounce_ticks     <= cfg_data;
        REG_WINDOW:   click_window_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= MODE_IDLE;
      click_count      <= '0;
      window_elapsed   <= '0;
      window_running   <= 1'b0;
      debounce_elapsed <= '0;
      debounce_running <= 1'b0;
    end else if (step) begin
      mode             <= mode_next;
      click_count      <= click_count_next;
      window_elapsed   <= window_elapsed_next;
      window_running   <= window_running_next;
      debounce_elapsed <= debounce_elapsed_next;
      debounce_running <= debounce_running_next;
    end
  end

  // The steps below follow one another within a tick; later steps see the
  // mode and timers as the earlier ones left them.
  always_comb begin
    logic              pressed;
    logic              deb_exp;
    mode_t             m;
    logic [CountW-1:0] cnt;
    logic [TimerW-1:0] w_el;
    logic              w_run;
    logic [TimerW-1:0] d_el;
    logic              d_run;
    event_t            ev;
    logic [TotalW-1:0] total;

    pressed = !pin_level;
    m       = mode;
    cnt     = click_count;
    w_el    = window_elapsed;
    w_run   = window_running;
    d_el    = debounce_elapsed;
    d_run   = debounce_running;
    ev      = EV_NONE;
    total   = '0;

    // Both timers advance at the start of the tick, saturating at full scale.
    if (w_run && (w_el != TimerMax)) w_el = TimerW'(w_el + 1'b1);
    if (d_run && (d_el != TimerMax)) d_el = TimerW'(d_el + 1'b1);
    deb_exp = d_run && (d_el >= debounce_ticks);

    if (pressed && (m == MODE_RELEASED) && !(w_run && (w_el >= click_window_ticks))) begin
      w_el  = '0;
      w_run = 1'b1;
      m     = MODE_PRESSED;
      if (cnt < CountW'(MaxClicks)) cnt = CountW'(cnt + 1'b1);
    end else if (pressed && (m == MODE_IDLE)) begin
      m     = MODE_ALMOST;
      d_el  = '0;
      d_run = 1'b1;
    end else if (pressed && (m == MODE_ALMOST) && deb_exp) begin
      m     = MODE_PRESSED;
      w_el  = '0;
      w_run = 1'b1;
      cnt   = CountW'(1);
    end else if (!pressed && (m == MODE_ALMOST) && !deb_exp) begin
      m     = MODE_IDLE;
      w_run = 1'b0;
      d_run = 1'b0;
    end

    if ((m == MODE_PRESSED) && !pressed) m = MODE_RELEASED;

    if ((m == MODE_PRESSED) && pressed && w_run && (w_el >= click_window_ticks)) begin
      m = MODE_HELD;
    end

    if ((m == MODE_HELD) && !pressed) begin
      w_run = 1'b0;
      m     = MODE_IDLE;
      ev    = EV_HOLD_RELEASED;
      cnt   = '0;
    end else if ((m == MODE_HELD) && pressed) begin
      ev = EV_HOLDING;
    end

    if (w_run && (w_el >= click_window_ticks) && (m == MODE_RELEASED)) begin
      w_run = 1'b0;
      ev    = EV_CLICKS_DONE;
      total = TotalW'(cnt);
      m     = MODE_IDLE;
    end

    mode_next             = m;
    click_count_next      = cnt;
    window_elapsed_next   = w_el;
    window_running_next   = w_run;
    debounce_elapsed_next = d_el;
    debounce_running_next = d_run;

    result.event_kind  = ev;
    result.click_total = total;
    result.button_mode = m;
  end

endmodule

@@ hdl/button_click_hold_detector.sv @@
// Top level of the button click / hold detector: handshakes and result buffering.
// Depends on bchd_pkg and instantiates bchd_fsm.

// The block takes one sampled, active-low button level per transfer and
// returns exactly one result per sample: an event code (none, holding, hold
// released, click sequence finished), the click total that goes with a
// finished sequence, and the button mode after the sample. A first press must
// persist for debounce_ticks samples; further presses inside the click window
// add clicks (saturating at the package maximum), and a press that outlasts
// the window becomes a hold, reported on every held sample and once more on
// release. Timing counts samples, not clock cycles. The block accepts one
// sample every clock cycle while sample_stall is low: the state machine and
// both timers are updated together per accepted sample, and its result is
// registered into the output register, or into a skid register while the
// output is stalled. The two result slots let one further sample be taken
// while result_stall is high; sample_stall rises only when both slots are
// full. Configuration writes land on the clock edge where cfg_write is high
// and should be made while no results are outstanding. After reset the
// debounce time is 50 and the click window is 400 samples.
module button_click_hold_detector (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [bchd_pkg::TimerW-1:0]   cfg_data,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic                          pin_level,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [1:0]                    event_kind,
  output logic [bchd_pkg::TotalW-1:0]   click_total,
  output logic [2:0]                    button_mode
);
  import bchd_pkg::*;

  logic    accept;
  logic    out_free;
  result_t step_result;
  result_t out_data;
  result_t skid_data;
  logic    skid_valid;

  // A transfer in happens whenever a sample is valid and the skid slot is empty.
  assign sample_stall = skid_valid;
  assign accept       = sample_valid && !skid_valid;

  // The output slot can take new data when it is empty or being drained.
  assign out_free     = !result_valid || !result_stall;

  bchd_fsm u_fsm (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (accept),
    .pin_level (pin_level),
    .result    (step_result)
  );

  // Control bits of the two result slots.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (out_free) begin
      // The skid slot drains first; a new sample is never taken while it is full.
      result_valid <= skid_valid || accept;
      skid_valid   <= 1'b0;
    end else begin
      skid_valid   <= skid_valid || accept;
    end
  end

  // Result payloads.
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (accept) begin
        out_data <= step_result;
      end
    end else if (accept) begin
      skid_data <= step_result;
    end
  end

  assign event_kind  = out_data.event_kind;
  assign click_total = out_data.click_total;
  assign button_mode = out_data.button_mode;

endmodule
